@@ src/ddcp_pkg.sv @@
package ddcp_pkg;

  // Widths of the item fields.
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int ELAPSED_W = 22;
  localparam int CYCLES_W  = 20;
  localparam int PHASE_W   = 3;

  // A day number counts days since 0001-01-01. The largest 14-bit year
  // keeps it below 2**23.
  localparam int DAYNUM_W = 23;

  localparam int DAYS_PER_YEAR = 365;

  // Division by 25 through a reciprocal. floor(x * 5243 / 2**17) equals
  // floor(x / 25) for every x below 43690, and the operands here stay below 4096.
  localparam int          RECIP25_SH = 17;
  localparam logic [12:0] RECIP25    = 13'd5243;
  localparam int          CENTURY_Q  = 25;

  // Result of one day-number pipeline: the day number and whether the date was valid.
  typedef struct packed {
    logic [DAYNUM_W-1:0] day_num;
    logic                ok;
  } day_num_t;

  // Days in the months before the given month of a common year.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Length of a month. A month code that is out of range gives zero.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ src/ddcp_day_number.sv @@
// Three-stage pipeline that turns a date into its day number and checks it.
module ddcp_day_number #(
  parameter int MAX_YEAR = 9999
) (
  input  logic                             clk,
  input  logic [ddcp_pkg::YEAR_W-1:0]      year,
  input  logic [ddcp_pkg::MONTH_W-1:0]     month,
  input  logic [ddcp_pkg::DAY_W-1:0]       day,
  output ddcp_pkg::day_num_t               result
);

  localparam int NW = ddcp_pkg::DAYNUM_W;
  localparam int SH = ddcp_pkg::RECIP25_SH;

  // Stage 1: constant products.
  logic [ddcp_pkg::YEAR_W-1:0] py;
  logic [NW-1:0]               py365;
  logic [24:0]                 p100;
  logic [22:0]                 p400;
  logic [24:0]                 y100p;
  logic [22:0]                 y400p;
  logic [11:0]                 py4;
  logic [11:0]                 y2;
  logic [9:0]                  y4;
  logic                        y_div4;
  logic                        y_div16;
  logic                        year_ok;
  logic [ddcp_pkg::MONTH_W-1:0] month1;
  logic [ddcp_pkg::DAY_W-1:0]   day1;

  assign py = year - 14'd1;

  always_ff @(posedge clk) begin
    py365   <= NW'(py) * NW'(ddcp_pkg::DAYS_PER_YEAR);
    p100    <= 25'(py[13:2]) * 25'(ddcp_pkg::RECIP25);
    p400    <= 23'(py[13:4]) * 23'(ddcp_pkg::RECIP25);
    y100p   <= 25'(year[13:2]) * 25'(ddcp_pkg::RECIP25);
    y400p   <= 23'(year[13:4]) * 23'(ddcp_pkg::RECIP25);
    py4     <= py[13:2];
    y2      <= year[13:2];
    y4      <= year[13:4];
    y_div4  <= (year[1:0] == 2'd0);
    y_div16 <= (year[3:0] == 4'd0);
    year_ok <= (year != '0) && (32'(year) <= 32'(MAX_YEAR));
    month1  <= month;
    day1    <= day;
  end

  // Stage 2: quotients, leap year, validity and the bulk of the sum.
  logic [7:0]            q100;
  logic [5:0]            q400;
  logic [7:0]            qy100;
  logic [5:0]            qy400;
  logic [11:0]           r100;
  logic [9:0]            r400;
  logic                  leap;
  logic [ddcp_pkg::DAY_W-1:0] mlen;
  logic [NW-1:0]         base2;
  logic [7:0]            q100_2;
  logic [5:0]            q400_2;
  logic                  adj2;
  logic                  ok2;

  always_comb begin
    q100  = p100[SH +: 8];
    q400  = p400[SH +: 6];
    qy100 = y100p[SH +: 8];
    qy400 = y400p[SH +: 6];
    r100  = y2 - 12'(qy100) * 12'(ddcp_pkg::CENTURY_Q);
    r400  = y4 - 10'(qy400) * 10'(ddcp_pkg::CENTURY_Q);
    // Divisible by 4, and either not a century or a multiple of 400.
    leap  = y_div4 && ((r100 != '0) || (y_div16 && (r400 == '0)));
    mlen  = ddcp_pkg::month_length(month1, leap);
  end

  always_ff @(posedge clk) begin
    base2  <= py365 + NW'(py4) + NW'(ddcp_pkg::days_before_month(month1))
              + NW'(day1) - NW'(1);
    q100_2 <= q100;
    q400_2 <= q400;
    adj2   <= leap && (month1 > 4'd2);
    ok2    <= year_ok && (month1 >= 4'd1) && (month1 <= 4'd12)
              && (day1 != '0) && (day1 <= mlen);
  end

  // Stage 3: century corrections and the leap day.
  always_ff @(posedge clk) begin
    result.day_num <= base2 - NW'(q100_2) + NW'(q400_2) + NW'(adj2);
    result.ok      <= ok2;
  end

endmodule

@@ src/date_difference_cycle_phase.sv @@
// Days between two Gregorian dates, with whole work/rest cycles and the phase in the
// current cycle. Raise start with both dates on the input ports. The item is taken at
// the clock edge where start is high and busy is low. busy is high only during reset,
// so a new item can be taken in every cycle. Each result is driven from
// the output registers of the last stage. It stays on elapsed_days,
// full_cycles, cycle_phase and date_error for one cycle, marked by done.
// Results come out in the order the items went in. The receiver cannot
// hold a result back, so it must capture every cycle in which done is
// high. The pipeline has six register stages: three stages compute the day number of
// each date (constant products, then quotients and validity, then the final sum). One
// stage takes the difference. The last two stages divide by the cycle length through
// a reciprocal multiply, then form the remainder. The start date is day zero. Leap
// years follow the rule of 4, 100 and 400. Phases 0 to 2 are work days and phases 3
// and 4 are rest days under the default five-day cycle. A date with a year outside 1
// to MAX_YEAR, a month outside 1 to 12, or a day outside its month is invalid. An
// invalid date, or an end date before the start date, sets date_error. It also forces
// all three counts to zero.
module date_difference_cycle_phase #(
  parameter int MAX_YEAR  = 9999,
  parameter int CYCLE_LEN = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ddcp_pkg::YEAR_W-1:0]        start_year,
  input  logic [ddcp_pkg::MONTH_W-1:0]       start_month,
  input  logic [ddcp_pkg::DAY_W-1:0]         start_day,
  input  logic [ddcp_pkg::YEAR_W-1:0]        end_year,
  input  logic [ddcp_pkg::MONTH_W-1:0]       end_month,
  input  logic [ddcp_pkg::DAY_W-1:0]         end_day,
  output logic                               done,
  output logic [ddcp_pkg::ELAPSED_W-1:0]     elapsed_days,
  output logic [ddcp_pkg::CYCLES_W-1:0]      full_cycles,
  output logic [ddcp_pkg::PHASE_W-1:0]       cycle_phase,
  output logic                               date_error
);

  localparam int NW      = ddcp_pkg::DAYNUM_W;
  localparam int LATENCY = 6;

  // The quotient floor(x * RECIP / 2**SH) is exact for every NW-bit x when SH is
  // NW + ceil(log2(CYCLE_LEN)) and RECIP is rounded up; RECIP fits in NW + 1 bits.
  localparam int          CL_BITS = $clog2(CYCLE_LEN);
  localparam int          SH      = NW + CL_BITS;
  localparam int          MW      = NW + 1;
  localparam int          PW      = NW + MW;
  localparam longint      RECIP_L = ((longint'(1) << SH) + longint'(CYCLE_LEN) - 1)
                                    / longint'(CYCLE_LEN);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // Valid bits travel alongside the data stages; done is the last of them.
  logic [LATENCY-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  assign done = vld[LATENCY-1];

  // Stages 1 to 3: one day-number pipeline for each date.
  ddcp_pkg::day_num_t start_num;
  ddcp_pkg::day_num_t end_num;

  ddcp_day_number #(.MAX_YEAR(MAX_YEAR)) u_start_num (
    .clk    (clk),
    .year   (start_year),
    .month  (start_month),
    .day    (start_day),
    .result (start_num)
  );

  ddcp_day_number #(.MAX_YEAR(MAX_YEAR)) u_end_num (
    .clk    (clk),
    .year   (end_year),
    .month  (end_month),
    .day    (end_day),
    .result (end_num)
  );

  // Stage 4: the span and the error flag.
  logic [NW-1:0] diff4;
  logic          err4;

  always_ff @(posedge clk) begin
    diff4 <= end_num.day_num - start_num.day_num;
    err4  <= !start_num.ok || !end_num.ok || (end_num.day_num < start_num.day_num);
  end

  // Stage 5: reciprocal product for the division by the cycle length.
  logic [PW-1:0] prod5;
  logic [NW-1:0] diff5;
  logic          err5;

  always_ff @(posedge clk) begin
    prod5 <= PW'(diff4) * PW'(RECIP);
    diff5 <= diff4;
    err5  <= err4;
  end

  // Stage 6: quotient, remainder and the registered result.
  logic [NW-1:0] quot;
  logic [NW-1:0] rem;

  always_comb begin
    quot = NW'(prod5 >> SH);
    rem  = diff5 - quot * NW'(CYCLE_LEN);
  end

  always_ff @(posedge clk) begin
    if (err5) begin
      elapsed_days <= '0;
      full_cycles  <= '0;
      cycle_phase  <= '0;
    end else begin
      elapsed_days <= diff5[ddcp_pkg::ELAPSED_W-1:0];
      full_cycles  <= quot[ddcp_pkg::CYCLES_W-1:0];
      cycle_phase  <= rem[ddcp_pkg::PHASE_W-1:0];
    end
    date_error <= err5;
  end

  // Every item taken comes out as a result, marked by done.
  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("item taken without a result six cycles later");

  // No result appears that no item caused.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("result without a matching item");

  // An error result carries zero counts.
  a_error_zeroes_counts: assert property (@(posedge clk) disable iff (rst)
    (done && date_error) |-> (elapsed_days == '0) && (full_cycles == '0)
                             && (cycle_phase == '0))
    else $error("error result with nonzero counts");

  // The remainder stage always lands below the cycle length.
  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(cycle_phase) < 32'(CYCLE_LEN)))
    else $error("cycle phase out of range");

endmodule
